/* design/fpa_pkg.sv */
// Package: opcodes, widths and pipeline word types for the fixed-point ALU
`default_nettype none
package fpa_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 4;

    typedef enum logic [OpW-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INCR     = 4'd6,
        OP_DECR     = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } t_op;

    // Control and status word that walks the divider row next to the data
    typedef struct packed {
        logic       vld;
        logic [3:0] op;
        logic       neg;
        logic       dz;
        logic       lt;
        logic       eq;
        logic       gt;
    } t_ctl;
endpackage
`default_nettype wire

/* design/fpa_cell.sv */
// One restoring-division cell: a single quotient bit per cycle, passes its word on
`default_nettype none
module fpa_cell #(
    parameter int unsigned NumW = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire fpa_pkg::t_ctl   i_ctl,
    input  wire [NumW-1:0]       i_num,
    input  wire [NumW-1:0]       i_rem,
    input  wire [31:0]           i_den,
    input  wire [31:0]           i_aux,
    output fpa_pkg::t_ctl        o_ctl,
    output logic [NumW-1:0]      o_num,
    output logic [NumW-1:0]      o_rem,
    output logic [31:0]          o_den,
    output logic [31:0]          o_aux
);
    logic [NumW-1:0] w_sh;
    logic [NumW:0]   w_diff;
    fpa_pkg::t_ctl   r_ctl;

    // shift in next dividend bit, trial subtract
    assign w_sh   = {i_rem[NumW-2:0], i_num[NumW-1]};
    assign w_diff = {1'b0, w_sh} - {{(NumW-31){1'b0}}, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // quotient bits fill num from the bottom as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        o_num <= {i_num[NumW-2:0], ~w_diff[NumW]};
        o_rem <= w_diff[NumW] ? w_sh : w_diff[NumW-1:0];
        o_den <= i_den;
        o_aux <= i_aux;
    end

    assign o_ctl = r_ctl;
endmodule
`default_nettype wire

/* design/fixed_point_alu_q24_8_unit.sv */
// Top level: fixed-point ALU, input stage, divider cell row and output select
//
//  channel  | dir | handshake          | words
//  request  | in  | i_start / o_busy   | i_req_type, i_operand_a, i_operand_b
//  result   | out | o_done (1 cycle)   | o_result, o_less, o_equal, o_greater,
//           |     |                    | o_div_by_zero
//
// Every opcode has the same latency: an input stage, 32+FRAC_BITS cells of the
// divider row (one quotient bit each) and an output register; a word enters each cycle.
// The multiplier is split into four 16x16 partial products in the input stage and
// summed in the following cycle, hidden behind the divider row.
// o_busy is always low; the receiver cannot stall. Synchronous active-low reset
// clears all valid bits; nothing is in flight after it.
`default_nettype none
module fixed_point_alu_q24_8_unit #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    output logic               o_busy,
    input  wire  [3:0]         i_req_type,
    input  wire  signed [31:0] i_operand_a,
    input  wire  signed [31:0] i_operand_b,
    output logic               o_done,
    output logic signed [31:0] o_result,
    output logic               o_less,
    output logic               o_equal,
    output logic               o_greater,
    output logic               o_div_by_zero
);
    localparam int unsigned NumW  = 32 + FRAC_BITS;
    localparam int unsigned Cells = NumW;

    // input stage
    fpa_pkg::t_ctl   n_ctl0;
    logic [NumW-1:0] n_num0;
    logic [31:0]     n_den0, n_aux0;
    logic [31:0]     w_abs_a, w_abs_b;
    logic [63:0]     w_sh_a;

    fpa_pkg::t_ctl   c_ctl [Cells+1];
    logic [NumW-1:0] c_num [Cells+1];
    logic [NumW-1:0] c_rem [Cells+1];
    logic [31:0]     c_den [Cells+1];
    logic [31:0]     c_aux [Cells+1];

    // multiplier partial products, summed in the next cycle
    logic [31:0] r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic        r_mneg;
    logic [63:0] r_prod;
    logic [31:0] w_mul_res;
    logic [63:0] w_sum, w_sprod;

    assign o_busy  = 1'b0;
    assign w_abs_a = i_operand_a[31] ? (~i_operand_a + 32'd1) : i_operand_a;
    assign w_abs_b = i_operand_b[31] ? (~i_operand_b + 32'd1) : i_operand_b;
    assign w_sh_a  = {{32{i_operand_a[31]}}, i_operand_a} >>> FRAC_BITS;

    always_comb begin
        n_ctl0.vld = i_start;
        n_ctl0.op  = i_req_type;
        n_ctl0.neg = i_operand_a[31] ^ i_operand_b[31];
        n_ctl0.dz  = (i_req_type == fpa_pkg::OP_DIV) && (i_operand_b == 32'sd0);
        n_ctl0.lt  = i_operand_a < i_operand_b;
        n_ctl0.eq  = i_operand_a == i_operand_b;
        n_ctl0.gt  = i_operand_a > i_operand_b;
        n_num0     = NumW'(w_abs_a) << FRAC_BITS;
        n_den0     = w_abs_b;
        // results other than multiply and divide are settled here and ride along the row
        case (i_req_type)
            fpa_pkg::OP_ADD:      n_aux0 = i_operand_a + i_operand_b;
            fpa_pkg::OP_SUB:      n_aux0 = i_operand_a - i_operand_b;
            fpa_pkg::OP_MIN:      n_aux0 = (i_operand_a < i_operand_b) ? i_operand_a
                                                                       : i_operand_b;
            fpa_pkg::OP_MAX:      n_aux0 = (i_operand_a > i_operand_b) ? i_operand_a
                                                                       : i_operand_b;
            fpa_pkg::OP_INCR:     n_aux0 = i_operand_a + 32'sd1;
            fpa_pkg::OP_DECR:     n_aux0 = i_operand_a - 32'sd1;
            fpa_pkg::OP_FROM_INT: n_aux0 = i_operand_a << FRAC_BITS;
            fpa_pkg::OP_TO_INT:   n_aux0 = w_sh_a[31:0];
            default:              n_aux0 = '0;
        endcase
    end

    // stage zero registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0] <= '0;
        end else begin
            c_ctl[0] <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        c_num[0] <= n_num0;
        c_rem[0] <= '0;
        c_den[0] <= n_den0;
        c_aux[0] <= n_aux0;
        r_pp_ll  <= w_abs_a[15:0] * w_abs_b[15:0];
        r_pp_lh  <= w_abs_a[15:0] * w_abs_b[31:16];
        r_pp_hl  <= w_abs_a[31:16] * w_abs_b[15:0];
        r_pp_hh  <= w_abs_a[31:16] * w_abs_b[31:16];
        r_mneg   <= i_operand_a[31] ^ i_operand_b[31];
    end

    // sum, sign and shift the product; held until the output stage picks it
    assign w_sum = {32'd0, r_pp_ll} + {16'd0, r_pp_lh, 16'd0}
                 + {16'd0, r_pp_hl, 16'd0} + {r_pp_hh, 32'd0};
    always_ff @(posedge i_clk) begin
        r_prod <= r_mneg ? (~w_sum + 64'd1) : w_sum;
    end
    assign w_sprod = $signed(r_prod) >>> FRAC_BITS;

    // multiply result delay line, Cells-1 deep to meet the row exit
    logic [31:0] r_mdly [Cells-1];
    always_ff @(posedge i_clk) begin
        r_mdly[0] <= w_sprod[31:0];
        for (int i = 1; i < Cells - 1; i++) begin
            r_mdly[i] <= r_mdly[i-1];
        end
    end
    assign w_mul_res = r_mdly[Cells-2];

    // the divider row
    for (genvar g = 0; g < Cells; g++) begin : g_cell
        fpa_cell #(.NumW(NumW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[g]),
            .i_num   (c_num[g]),
            .i_rem   (c_rem[g]),
            .i_den   (c_den[g]),
            .i_aux   (c_aux[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_num   (c_num[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_den   (c_den[g+1]),
            .o_aux   (c_aux[g+1])
        );
    end

    // output stage
    fpa_pkg::t_ctl w_ce;
    logic [31:0]   w_q, n_res;
    assign w_ce = c_ctl[Cells];
    assign w_q  = c_num[Cells][31:0];

    always_comb begin
        case (w_ce.op)
            fpa_pkg::OP_MUL: n_res = w_mul_res;
            fpa_pkg::OP_DIV: n_res = w_ce.dz ? 32'd0 : (w_ce.neg ? (~w_q + 32'd1) : w_q);
            default:         n_res = c_aux[Cells];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_ce.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result      <= n_res;
        o_less        <= w_ce.lt;
        o_equal       <= w_ce.eq;
        o_greater     <= w_ce.gt;
        o_div_by_zero <= w_ce.dz;
    end

    // exactly one compare flag on every result
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot({o_less, o_equal, o_greater}))
        else $error("compare flags not one-hot");
    // divide by zero forces a zero result
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_div_by_zero) |-> (o_result == 32'sd0))
        else $error("div by zero result not zero");
    // a dz flag only travels with a divide request
    a_dzop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[0].dz |-> (c_ctl[0].op == fpa_pkg::OP_DIV))
        else $error("dz on non-divide");
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for the fixed-point ALU: directed and random words checked against a predictor
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FracBits = 8;
    localparam int unsigned Latency  = 32 + FracBits + 2;

    typedef struct {
        logic signed [31:0] result;
        logic               less;
        logic               equal;
        logic               greater;
        logic               div_by_zero;
    } t_alu_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [3:0]         i_req_type = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    wire                o_busy;
    wire                o_done;
    wire signed [31:0]  o_result;
    wire                o_less;
    wire                o_equal;
    wire                o_greater;
    wire                o_div_by_zero;

    t_alu_word pending_words[$];
    int        fail_count = 0;

    fixed_point_alu_q24_8_unit #(.FRAC_BITS(FracBits)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_req_type(i_req_type), .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b), .o_done(o_done), .o_result(o_result),
        .o_less(o_less), .o_equal(o_equal), .o_greater(o_greater),
        .o_div_by_zero(o_div_by_zero)
    );

    always #5 i_clk = ~i_clk;

    // Expected result of one request
    function automatic t_alu_word alu_predict(logic [3:0] op, logic signed [31:0] a,
                                             logic signed [31:0] b);
        t_alu_word          w;
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] prod;
        wa = 64'(a);
        wb = 64'(b);
        w.result      = '0;
        w.div_by_zero = 1'b0;
        w.less        = a < b;
        w.equal       = a == b;
        w.greater     = a > b;
        case (op)
            fpa_pkg::OP_ADD:  w.result = a + b;
            fpa_pkg::OP_SUB:  w.result = a - b;
            fpa_pkg::OP_MUL: begin
                prod = wa * wb;
                w.result = 32'(prod >>> FracBits);
            end
            fpa_pkg::OP_DIV: begin
                if (b == 0) w.div_by_zero = 1'b1;
                else w.result = 32'((wa <<< FracBits) / wb);
            end
            fpa_pkg::OP_MIN:      w.result = (a < b) ? a : b;
            fpa_pkg::OP_MAX:      w.result = (a > b) ? a : b;
            fpa_pkg::OP_INCR:     w.result = a + 1;
            fpa_pkg::OP_DECR:     w.result = a - 1;
            fpa_pkg::OP_FROM_INT: w.result = a << FracBits;
            fpa_pkg::OP_TO_INT:   w.result = a >>> FracBits;
            default:              w.result = '0;
        endcase
        return w;
    endfunction

    // Send one word; waits for the block to accept it
    task automatic send_word(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
        i_start     <= 1'b1;
        i_req_type  <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_words.push_back(alu_predict(op, a, b));
    endtask

    // a zero-length gap leaves start alone so the next word follows directly
    task automatic idle_cycles(int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_alu_word exp_w;
        if (i_rst_n && o_done) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                exp_w = pending_words.pop_front();
                if (o_result !== exp_w.result) begin
                    $error("result: expected %0d, got %0d", exp_w.result, o_result);
                    fail_count++;
                end
                if (o_less !== exp_w.less) begin
                    $error("less: expected %0b, got %0b", exp_w.less, o_less);
                    fail_count++;
                end
                if (o_equal !== exp_w.equal) begin
                    $error("equal: expected %0b, got %0b", exp_w.equal, o_equal);
                    fail_count++;
                end
                if (o_greater !== exp_w.greater) begin
                    $error("greater: expected %0b, got %0b", exp_w.greater, o_greater);
                    fail_count++;
                end
                if (o_div_by_zero !== exp_w.div_by_zero) begin
                    $error("div_by_zero: expected %0b, got %0b",
                           exp_w.div_by_zero, o_div_by_zero);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return 32'($signed($urandom_range(0, 2047)) - 1024);
            4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // Edge values on every opcode, divide by zero and the unused opcodes
    task automatic test_directed();
        fpa_pkg::t_op op;
        send_word(fpa_pkg::OP_ADD, 32'sh7fff_ffff, 32'sh0000_0001);
        send_word(fpa_pkg::OP_SUB, 32'sh8000_0000, 32'sh0000_0001);
        send_word(fpa_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
        send_word(fpa_pkg::OP_MUL, -32'sd1, 32'sd1);
        send_word(fpa_pkg::OP_DIV, 32'sh7fff_ffff, 32'sd0);
        send_word(fpa_pkg::OP_DIV, 32'sh8000_0000, -32'sd1);
        send_word(fpa_pkg::OP_DIV, -32'sd3, 32'sd512);
        send_word(fpa_pkg::OP_MIN, 32'sd5, 32'sd5);
        send_word(fpa_pkg::OP_MAX, 32'sh8000_0000, 32'sh7fff_ffff);
        send_word(fpa_pkg::OP_INCR, 32'sh7fff_ffff, 32'sd0);
        send_word(fpa_pkg::OP_DECR, 32'sh8000_0000, 32'sd0);
        send_word(fpa_pkg::OP_FROM_INT, 32'sh00ff_ffff, 32'sd1);
        send_word(fpa_pkg::OP_FROM_INT, 32'sh8000_0001, -32'sd1);
        send_word(fpa_pkg::OP_TO_INT, -32'sd1, 32'sd0);
        send_word(fpa_pkg::OP_TO_INT, 32'sh7fff_ffff, 32'sh8000_0000);
        for (int i = 10; i < 16; i++) send_word(4'(i), $urandom, $urandom);
        op = op.first();
        do begin
            send_word(op, $urandom, $urandom);
            op = op.next();
        end while (op != op.first());
        idle_cycles(1);
    endtask

    // Random words in bursts with random gaps
    task automatic test_random(int n_words);
        int sent;
        int burst;
        logic [3:0] op;
        logic signed [31:0] a;
        sent = 0;
        while (sent < n_words) begin
            burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n_words; i++) begin
                op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(0, 9));
                a = rand_operand();
                send_word(op, a, ($urandom_range(0, 5) == 0) ? a : rand_operand());
                sent++;
            end
            idle_cycles($urandom_range(0, 6));
        end
        idle_cycles(1);
    endtask

    // Hold off until the pipe has drained, then resume
    task automatic test_drain_pause();
        while (pending_words.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 10; i++) send_word(4'($urandom_range(0, 9)), $urandom, $urandom);
        idle_cycles(1);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        test_drain_pause();
        test_random(220);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** fixed_point_alu_q24_8_unit: PASSED **");
        end else begin
            $display("** fixed_point_alu_q24_8_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("** fixed_point_alu_q24_8_unit: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
design/fpa_pkg.sv
design/fpa_cell.sv
design/fixed_point_alu_q24_8_unit.sv
tb/sv/testbench.sv
